// ===== rtl/urm_pkg.sv =====
// Shared types, constants and the code-index length table for the
// USB-MIDI unpacker / note tracker. No dependencies.
package urm_pkg;

  // Active-note map held as 128 rows of 16 bits; index = channel*128 + note
  localparam int unsigned NoteIdxW = 11;
  localparam int unsigned RowBits  = 16;
  localparam int unsigned RowIdxW  = 4;
  localparam int unsigned RowCount = 128;
  localparam int unsigned RowAddrW = 7;

  localparam logic [3:0] KindNoteOff = 4'h8;
  localparam logic [3:0] KindNoteOn  = 4'h9;
  localparam logic [3:0] KindCtrl    = 4'hB;
  localparam logic [3:0] LastChannel = 4'hF;
  localparam logic [7:0] CcNotesOff  = 8'd123;
  localparam logic [7:0] CcSoundOff  = 8'd120;
  localparam logic [1:0] LenThree    = 2'd3;
  localparam logic [1:0] LenNone     = 2'd0;

  typedef struct packed {
    logic       opcode;
    logic [7:0] header_byte;
    logic [7:0] midi_byte_one;
    logic [7:0] midi_byte_two;
    logic [7:0] midi_byte_three;
  } in_item_t;

  typedef struct packed {
    logic [1:0] message_length;
    logic [7:0] out_byte_zero;
    logic [7:0] out_byte_one;
    logic [7:0] out_byte_two;
    logic       panic_done;
  } out_item_t;

  typedef enum logic [1:0] {
    ROW_SET,
    ROW_CLR,
    ROW_FIND
  } row_op_e;

  typedef struct packed {
    logic [RowBits-1:0] row;
    logic               found;
    logic [RowIdxW-1:0] bit_idx;
  } row_res_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SCAN,
    PH_CC
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NOTE_RD,
    ST_NOTE_WR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_CC,
    ST_PUT
  } state_e;

  // MIDI message length for each USB-MIDI code index
  function automatic logic [1:0] msg_len(input logic [3:0] cin);
    logic [1:0] len;
    unique case (cin)
      4'h0, 4'h1:                      len = 2'd0;
      4'h5, 4'hF:                      len = 2'd1;
      4'h2, 4'h6, 4'hC, 4'hD:          len = 2'd2;
      default:                         len = 2'd3;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/urm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module urm_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 128,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ===== rtl/urm_row_unit.sv =====
// Shared row unit: sets or clears one bit of a 16-bit map row, or finds and
// clears the first set bit at or above a start position. Uses urm_pkg.
module urm_row_unit (
  input  logic [urm_pkg::RowBits-1:0] row_i,
  input  urm_pkg::row_op_e            op_i,
  input  logic [urm_pkg::RowIdxW-1:0] bit_i,
  output urm_pkg::row_res_t           res_o
);

  import urm_pkg::*;

  logic               hit;
  logic [RowIdxW-1:0] hit_idx;

  // priority search, lowest qualifying bit wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = RowBits - 1; i >= 0; i--) begin
      if (row_i[i] && (RowIdxW'(i) >= bit_i)) begin
        hit     = 1'b1;
        hit_idx = RowIdxW'(i);
      end
    end
  end

  always_comb begin
    res_o.row     = row_i;
    res_o.found   = hit;
    res_o.bit_idx = hit_idx;
    unique case (op_i)
      ROW_SET:  res_o.row[bit_i] = 1'b1;
      ROW_CLR:  res_o.row[bit_i] = 1'b0;
      ROW_FIND: begin
        if (hit) begin
          res_o.row[hit_idx] = 1'b0;
        end
      end
      default:  res_o.row = row_i;
    endcase
  end

endmodule

// ===== rtl/usb_midi_unpacker_note_tracker_core.sv =====
// Top level: USB-MIDI event packet unpacker with a 16x128 active-note map
// and a stepped panic run. Uses urm_pkg, urm_ram and urm_row_unit.
//
//  channel | signals                           | carries
//  --------+-----------------------------------+--------------------------------
//  in      | in_valid_i / in_ready_o / in_item_i | packet or panic step (in_item_t)
//  out     | out_valid_o / out_ready_i / out_item_o | one MIDI message (out_item_t)
//
// Steps: a packet that leaves the map alone goes straight to output; a
// note-on/off takes a row read, a row write through the row unit, then
// output. A panic step scans the map from its saved position, one 16-bit
// RAM row per read and check state pair; controller messages pass the CC
// state. The single RAM and row unit set these steps. in_ready_o is high only
// while the sequencer is idle; one finished item may wait in the output
// register while the next is taken. After reset the map reads as cleared at
// once: each row has a valid bit, and an invalid row reads as zero, so there
// is no clearing pass.
module usb_midi_unpacker_note_tracker_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  urm_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output urm_pkg::out_item_t out_item_o
);

  import urm_pkg::*;

  state_e              state_q, state_d;
  phase_e              phase_q, phase_d;
  logic [NoteIdxW-1:0] scan_q, scan_d;
  logic [3:0]          cc_chan_q, cc_chan_d;
  logic                cc_second_q, cc_second_d;
  logic [RowCount-1:0] row_valid_q, row_valid_d;
  in_item_t            item_q, item_d;
  out_item_t           res_q, res_d;
  out_item_t           out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic                accept;
  logic                out_free;
  logic [1:0]          in_len;
  logic                in_touch;
  logic                note_phase;
  logic [RowAddrW-1:0] busy_row;
  logic [NoteIdxW-1:0] hit_note;
  logic                ram_rd_en, ram_wr_en;
  logic [RowBits-1:0]  ram_rdata;
  logic [RowBits-1:0]  unit_row;
  row_op_e             unit_op;
  logic [RowIdxW-1:0]  unit_bit;
  row_res_t            unit_res;
  out_item_t           pkt_res;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // packet decode straight off the input, used at the accepting edge
  assign in_len   = msg_len(in_item_i.header_byte[3:0]);
  assign in_touch = (in_len == LenThree) &&
                    ((in_item_i.midi_byte_one[7:4] == KindNoteOn) ||
                     (in_item_i.midi_byte_one[7:4] == KindNoteOff));

  always_comb begin
    pkt_res.message_length = in_len;
    pkt_res.out_byte_zero  = in_item_i.midi_byte_one;
    pkt_res.out_byte_one   = (in_len >= 2'd2) ? in_item_i.midi_byte_two : 8'h00;
    pkt_res.out_byte_two   = (in_len == LenThree) ? in_item_i.midi_byte_three : 8'h00;
    pkt_res.panic_done     = 1'b0;
  end

  // row in work: the note's row for an update, the scan row otherwise
  assign note_phase = (state_q == ST_NOTE_RD) || (state_q == ST_NOTE_WR);
  assign busy_row   = note_phase ? {item_q.midi_byte_one[3:0], item_q.midi_byte_two[6:4]}
                                 : scan_q[NoteIdxW-1:RowIdxW];
  assign unit_row   = row_valid_q[busy_row] ? ram_rdata : '0;
  assign unit_bit   = note_phase ? item_q.midi_byte_two[3:0] : scan_q[RowIdxW-1:0];
  assign hit_note   = {busy_row, unit_res.bit_idx};

  always_comb begin
    if (!note_phase) begin
      unit_op = ROW_FIND;
    end else if ((item_q.midi_byte_one[7:4] == KindNoteOn) &&
                 (item_q.midi_byte_three != 8'h00)) begin
      unit_op = ROW_SET;
    end else begin
      unit_op = ROW_CLR;
    end
  end

  urm_row_unit u_row_unit (
    .row_i (unit_row),
    .op_i  (unit_op),
    .bit_i (unit_bit),
    .res_o (unit_res)
  );

  urm_ram #(
    .Width (RowBits),
    .Depth (RowCount)
  ) u_note_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (busy_row),
    .wr_data_i (unit_res.row),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (busy_row),
    .rd_data_o (ram_rdata)
  );

  // sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_item_i.opcode) begin
            state_d = (phase_q == PH_CC) ? ST_CC : ST_SCAN_RD;
          end else if (in_len == LenNone) begin
            state_d = ST_IDLE;  // nothing to send, all-zero packets included
          end else if (in_touch) begin
            state_d = ST_NOTE_RD;
          end else begin
            state_d = ST_PUT;
          end
        end
      end
      ST_NOTE_RD:  state_d = ST_NOTE_WR;
      ST_NOTE_WR:  state_d = ST_PUT;
      ST_SCAN_RD:  state_d = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (unit_res.found) begin
          state_d = ST_PUT;
        end else if (busy_row == RowAddrW'(RowCount - 1)) begin
          state_d = ST_CC;
        end else begin
          state_d = ST_SCAN_RD;
        end
      end
      ST_CC:       state_d = ST_PUT;
      ST_PUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // sequencer: datapath and RAM control
  always_comb begin
    phase_d     = phase_q;
    scan_d      = scan_q;
    cc_chan_d   = cc_chan_q;
    cc_second_d = cc_second_q;
    row_valid_d = row_valid_q;
    item_d      = item_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_rd_en   = 1'b0;
    ram_wr_en   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          item_d = in_item_i;
          res_d  = pkt_res;
          // panic step out of idle opens a new run
          if (in_item_i.opcode && (phase_q != PH_SCAN) && (phase_q != PH_CC)) begin
            phase_d     = PH_SCAN;
            scan_d      = '0;
            cc_chan_d   = '0;
            cc_second_d = 1'b0;
          end
        end
      end
      ST_NOTE_RD: ram_rd_en = 1'b1;
      ST_NOTE_WR: begin
        ram_wr_en             = 1'b1;
        row_valid_d[busy_row] = 1'b1;
      end
      ST_SCAN_RD: ram_rd_en = 1'b1;
      ST_SCAN_CHK: begin
        if (unit_res.found) begin
          ram_wr_en                 = 1'b1;
          row_valid_d[busy_row]     = 1'b1;
          res_d.message_length      = LenThree;
          res_d.out_byte_zero       = {KindNoteOff, hit_note[NoteIdxW-1:7]};
          res_d.out_byte_one        = {1'b0, hit_note[6:0]};
          res_d.out_byte_two        = 8'h00;
          res_d.panic_done          = 1'b0;
          if (hit_note == '1) begin
            // last map entry ends the scan
            phase_d     = PH_CC;
            scan_d      = '0;
            cc_chan_d   = '0;
            cc_second_d = 1'b0;
          end else begin
            scan_d = hit_note + NoteIdxW'(1);
          end
        end else if (busy_row == RowAddrW'(RowCount - 1)) begin
          phase_d     = PH_CC;
          scan_d      = '0;
          cc_chan_d   = '0;
          cc_second_d = 1'b0;
        end else begin
          scan_d = {busy_row + RowAddrW'(1), RowIdxW'(0)};
        end
      end
      ST_CC: begin
        res_d.message_length = LenThree;
        res_d.out_byte_zero  = {KindCtrl, cc_chan_q};
        res_d.out_byte_one   = cc_second_q ? CcSoundOff : CcNotesOff;
        res_d.out_byte_two   = 8'h00;
        res_d.panic_done     = cc_second_q && (cc_chan_q == LastChannel);
        cc_second_d          = !cc_second_q;
        if (cc_second_q) begin
          if (cc_chan_q == LastChannel) begin
            phase_d   = PH_IDLE;
            cc_chan_d = '0;
          end else begin
            cc_chan_d = cc_chan_q + 4'd1;
          end
        end
      end
      ST_PUT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_IDLE;
      scan_q      <= '0;
      cc_chan_q   <= '0;
      cc_second_q <= 1'b0;
      row_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      scan_q      <= scan_d;
      cc_chan_q   <= cc_chan_d;
      cc_second_q <= cc_second_d;
      row_valid_q <= row_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

endmodule
